// ===== rtl/five_point_interval_halving_search_macros.svh =====
// Assertion macros for the five-point interval halving search block.
`ifndef FIVE_POINT_INTERVAL_HALVING_SEARCH_MACROS_SVH
`define FIVE_POINT_INTERVAL_HALVING_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF
// Plain property, checked on every rising clock edge outside reset.
`define FPIHS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Implication: when ante holds, cons must hold in the next cycle.
`define FPIHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define FPIHS_ASSERT(lbl, clk, rstn, prop, msg)
`define FPIHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/fpihs_pkg.sv =====
// Shared constants and codes for the five-point interval halving search.
package fpihs_pkg;

	localparam int POINT_WIDTH = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int ROUND_WIDTH = 8;

	localparam logic [ROUND_WIDTH-1:0] ROUND_LIMIT_RESET = 8'd16;

	// command field of an input item
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_VALUE = 1'b1;

	// result_kind field of a result item
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_ANSWER  = 1'b1;

endpackage

// ===== rtl/fpihs_if.sv =====
// Channel interfaces: command items in, request/answer items out.
interface fpihs_cmd_if #(
	parameter int POINT_WIDTH = fpihs_pkg::POINT_WIDTH
);
	logic                                   valid;
	logic                                   ready;
	logic                                   command;
	logic signed [POINT_WIDTH-1:0]          left_end;
	logic signed [POINT_WIDTH-1:0]          right_end;
	logic signed [fpihs_pkg::VALUE_WIDTH-1:0] func_value;

	modport source (output valid, command, left_end, right_end, func_value, input ready);
	modport sink   (input valid, command, left_end, right_end, func_value, output ready);
endinterface

interface fpihs_rsp_if #(
	parameter int POINT_WIDTH = fpihs_pkg::POINT_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic                          result_kind;
	logic signed [POINT_WIDTH-1:0] point;

	modport source (output valid, result_kind, point, input ready);
	modport sink   (input valid, result_kind, point, output ready);
endinterface

// ===== rtl/five_point_interval_halving_search.sv =====
// Five-point interval halving search controller (top level).
//
// Usage: send a start item (command = start) on cmd with the left and right
// ends of the interval, signed Q16.16. The block answers on rsp with a
// request item naming a point; the user evaluates the function there and
// returns the value in a value item (command = value). Points are asked in
// the order left, centre, right, then two quarter points per round. When the
// least of the five samples sits at an end, or round_limit rounds are done,
// rsp carries an answer item instead of a request. A value item while idle
// is dropped without result; a start item restarts the search at any time.
// round_limit is written through round_limit_we/round_limit_wdata.
// A result is registered and appears on rsp in the cycle after its item is accepted.
// Throughput: one item per cycle while rsp is not stalled; all work sits
// between the cmd handshake and a single result register, so one midpoint
// adder and the five-way compare set the cycle.
// Stall: cmd.ready stays high while the result register is empty or being
// taken, so a stalled receiver holds the result and blocks new items.
// Reset: arst_n clears the search to idle, round_limit to 16, result empty.
module five_point_interval_halving_search #(
	parameter int POINT_WIDTH = fpihs_pkg::POINT_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	fpihs_cmd_if.sink                        cmd,
	fpihs_rsp_if.source                      rsp,
	input  logic                             round_limit_we,
	input  logic [fpihs_pkg::ROUND_WIDTH-1:0] round_limit_wdata
);

	localparam int VW = fpihs_pkg::VALUE_WIDTH;
	localparam int RW = fpihs_pkg::ROUND_WIDTH;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LEFT   = 3'd1,
		PH_CENTRE = 3'd2,
		PH_RIGHT  = 3'd3,
		PH_Q1     = 3'd4,
		PH_Q3     = 3'd5
	} phase_t;

	typedef logic signed [POINT_WIDTH-1:0] point_t;
	typedef logic signed [VW-1:0]          value_t;

	// Search state: points in order left, q1, centre, q3, right.
	phase_t          phase_q;
	logic [RW-1:0]   rounds_q;
	logic [RW-1:0]   round_limit_q;
	point_t          pts_q [5];
	value_t          val0_q, val1_q, val2_q, val4_q;

	// Result register
	logic            rsp_valid_q;
	logic            rsp_kind_q;
	point_t          rsp_point_q;

	// Next-state values
	phase_t          phase_d;
	logic [RW-1:0]   rounds_d;
	point_t          pts_d [5];
	value_t          val0_d, val1_d, val2_d, val4_d;
	logic            emit;
	logic            kind_d;
	point_t          point_d;

	logic            accept;
	value_t          v;

	// Five-way argmin over the samples, the third quarter value arriving now
	value_t          cand [5];
	logic [4:0]      win;
	logic [2:0]      best;
	point_t          nl, nc, nr;
	value_t          vl, vc, vr;

	// Shared midpoint adder
	point_t               mid_a, mid_b, mid;
	logic signed [POINT_WIDTH:0] mid_sum;

	logic [RW-1:0]   rounds_inc;
	logic [RW-1:0]   rounds_chk;
	logic            limit_hit;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign v         = cmd.func_value;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.result_kind = rsp_kind_q;
	assign rsp.point       = rsp_point_q;

	assign cand[0] = val0_q;
	assign cand[1] = val1_q;
	assign cand[2] = val2_q;
	assign cand[3] = v;
	assign cand[4] = val4_q;

	// An entry wins when it is strictly below every earlier one and no later
	// one is strictly below it: the lowest index among equal minima.
	always_comb begin
		for (int i = 0; i < 5; i++) begin
			win[i] = 1'b1;
			for (int j = 0; j < 5; j++) begin
				if (j < i && !(cand[i] < cand[j]))
					win[i] = 1'b0;
				if (j > i && (cand[j] < cand[i]))
					win[i] = 1'b0;
			end
		end
	end

	always_comb begin
		priority if (win[0]) best = 3'd0;
		else if (win[1])     best = 3'd1;
		else if (win[2])     best = 3'd2;
		else if (win[3])     best = 3'd3;
		else                 best = 3'd4;
	end

	// Narrowed triple around an inner winner
	always_comb begin
		unique case (best)
			3'd1: begin
				nl = pts_q[0]; nc = pts_q[1]; nr = pts_q[2];
				vl = val0_q;   vc = val1_q;   vr = val2_q;
			end
			3'd2: begin
				nl = pts_q[1]; nc = pts_q[2]; nr = pts_q[3];
				vl = val1_q;   vc = val2_q;   vr = v;
			end
			default: begin
				nl = pts_q[2]; nc = pts_q[3]; nr = pts_q[4];
				vl = val2_q;   vc = v;        vr = val4_q;
			end
		endcase
	end

	// Operands of the midpoint for whatever this item needs
	always_comb begin
		if (cmd.command == fpihs_pkg::CMD_START) begin
			mid_a = cmd.left_end;
			mid_b = cmd.right_end;
		end else begin
			unique case (phase_q)
				PH_Q1: begin
					mid_a = pts_q[2];
					mid_b = pts_q[4];
				end
				PH_Q3: begin
					mid_a = nl;
					mid_b = nc;
				end
				default: begin
					mid_a = pts_q[0];
					mid_b = pts_q[2];
				end
			endcase
		end
	end

	// Floor of the exact sum halved: one extra bit, drop the lowest
	assign mid_sum = {mid_a[POINT_WIDTH-1], mid_a} + {mid_b[POINT_WIDTH-1], mid_b};
	assign mid     = mid_sum[POINT_WIDTH:1];

	assign rounds_inc = rounds_q + 1'b1;
	assign rounds_chk = (phase_q == PH_Q3) ? rounds_inc : rounds_q;
	assign limit_hit  = rounds_chk >= round_limit_q;

	always_comb begin
		phase_d  = phase_q;
		rounds_d = rounds_q;
		for (int i = 0; i < 5; i++)
			pts_d[i] = pts_q[i];
		val0_d   = val0_q;
		val1_d   = val1_q;
		val2_d   = val2_q;
		val4_d   = val4_q;
		emit     = 1'b0;
		kind_d   = fpihs_pkg::KIND_REQUEST;
		point_d  = pts_q[0];

		if (cmd.command == fpihs_pkg::CMD_START) begin
			// Load the ends, ask for the left end first
			pts_d[0] = cmd.left_end;
			pts_d[4] = cmd.right_end;
			pts_d[2] = mid;
			rounds_d = '0;
			phase_d  = PH_LEFT;
			emit     = 1'b1;
			point_d  = cmd.left_end;
		end else begin
			unique case (phase_q)
				PH_LEFT: begin
					val0_d  = v;
					phase_d = PH_CENTRE;
					emit    = 1'b1;
					point_d = pts_q[2];
				end
				PH_CENTRE: begin
					val2_d  = v;
					phase_d = PH_RIGHT;
					emit    = 1'b1;
					point_d = pts_q[4];
				end
				PH_RIGHT: begin
					val4_d = v;
					emit   = 1'b1;
					if (limit_hit) begin
						phase_d = PH_IDLE;
						kind_d  = fpihs_pkg::KIND_ANSWER;
						point_d = pts_q[2];
					end else begin
						pts_d[1] = mid;
						phase_d  = PH_Q1;
						point_d  = mid;
					end
				end
				PH_Q1: begin
					val1_d   = v;
					pts_d[3] = mid;
					phase_d  = PH_Q3;
					emit     = 1'b1;
					point_d  = mid;
				end
				PH_Q3: begin
					emit = 1'b1;
					if (best == 3'd0 || best == 3'd4) begin
						// Minimum at an end: answer with it
						phase_d = PH_IDLE;
						kind_d  = fpihs_pkg::KIND_ANSWER;
						point_d = (best == 3'd0) ? pts_q[0] : pts_q[4];
					end else begin
						pts_d[0] = nl;
						pts_d[2] = nc;
						pts_d[4] = nr;
						val0_d   = vl;
						val2_d   = vc;
						val4_d   = vr;
						rounds_d = rounds_inc;
						if (limit_hit) begin
							phase_d = PH_IDLE;
							kind_d  = fpihs_pkg::KIND_ANSWER;
							point_d = nc;
						end else begin
							pts_d[1] = mid;
							phase_d  = PH_Q1;
							point_d  = mid;
						end
					end
				end
				default: begin
					// Idle or an unused code: drop the value
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			rounds_q      <= '0;
			round_limit_q <= fpihs_pkg::ROUND_LIMIT_RESET;
			for (int i = 0; i < 5; i++)
				pts_q[i] <= '0;
			val0_q        <= '0;
			val1_q        <= '0;
			val2_q        <= '0;
			val4_q        <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_kind_q    <= fpihs_pkg::KIND_REQUEST;
			rsp_point_q   <= '0;
		end else begin
			if (round_limit_we)
				round_limit_q <= round_limit_wdata;
			if (accept) begin
				phase_q  <= phase_d;
				rounds_q <= rounds_d;
				for (int i = 0; i < 5; i++)
					pts_q[i] <= pts_d[i];
				val0_q      <= val0_d;
				val1_q      <= val1_d;
				val2_q      <= val2_d;
				val4_q      <= val4_d;
				rsp_valid_q <= emit;
				if (emit) begin
					rsp_kind_q  <= kind_d;
					rsp_point_q <= point_d;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`include "five_point_interval_halving_search_macros.svh"

	`FPIHS_ASSERT_NEXT(a_start_asks_left, clk, arst_n, accept && cmd.command == fpihs_pkg::CMD_START, rsp_valid_q && rsp_kind_q == fpihs_pkg::KIND_REQUEST && rsp_point_q == $past(cmd.left_end) && phase_q == PH_LEFT, "start item did not request the left end")
	`FPIHS_ASSERT_NEXT(a_idle_value_dropped, clk, arst_n, accept && cmd.command == fpihs_pkg::CMD_VALUE && phase_q == PH_IDLE, !rsp_valid_q && phase_q == PH_IDLE, "value item while idle produced a result")
	`FPIHS_ASSERT_NEXT(a_answer_ends_search, clk, arst_n, accept && emit && kind_d == fpihs_pkg::KIND_ANSWER, phase_q == PH_IDLE && rsp_kind_q == fpihs_pkg::KIND_ANSWER, "answer issued but search not idle")
	`FPIHS_ASSERT_NEXT(a_q1_asks_q3, clk, arst_n, accept && cmd.command == fpihs_pkg::CMD_VALUE && phase_q == PH_Q1, phase_q == PH_Q3 && rsp_valid_q && rsp_kind_q == fpihs_pkg::KIND_REQUEST, "first quarter value did not request the third quarter")

endmodule
